// ===== src/cldc_pkg.sv =====
// ----------------------------------------------------------------------------
// Lamp dimmer command handler package
// Shared types, opcodes, scene codes and the channel 3 gamma table.
// ----------------------------------------------------------------------------
package cldc_pkg;

    localparam int CHANNELS = 4;
    localparam int CH_W     = $clog2(CHANNELS);

    // Defaults for the top level parameters.
    localparam logic [5:0] LAMP_PORT_DEF  = 6'd1;
    localparam logic [5:0] MGMT_PORT_DEF  = 6'd0;
    localparam logic [7:0] PING_CODE_DEF  = 8'd1;
    localparam logic [7:0] RESET_CODE_DEF = 8'd0;

    localparam logic [7:0] LEVEL_MAX      = 8'd255;
    localparam logic [8:0] WINDOW_DEFAULT = 9'd305;

    // Item kind.
    localparam logic CMD_MESSAGE = 1'b0;
    localparam logic CMD_TICK    = 1'b1;

    // Lamp port opcodes.
    localparam logic [7:0] OP_SCENE     = 8'd0;
    localparam logic [7:0] OP_SET_LEVEL = 8'd1;
    localparam logic [7:0] OP_RAMP_STEP = 8'd2;
    localparam logic [7:0] OP_RAMP_FLIP = 8'd3;
    localparam logic [7:0] OP_ENABLE    = 8'd4;

    // Scene cycle steps.
    localparam logic [1:0] SCENE_OFF    = 2'd0;
    localparam logic [1:0] SCENE_MAIN   = 2'd1;
    localparam logic [1:0] SCENE_ACCENT = 2'd2;
    localparam logic [1:0] SCENE_ALL    = 2'd3;

    localparam logic [CHANNELS-1:0] MASK_OFF    = 4'h0;
    localparam logic [CHANNELS-1:0] MASK_MAIN   = 4'h7;
    localparam logic [CHANNELS-1:0] MASK_ACCENT = 4'h8;
    localparam logic [CHANNELS-1:0] MASK_ALL    = 4'hF;

    // Configuration register indexes.
    localparam logic REG_NODE_ADDRESS = 1'b0;
    localparam logic REG_WINDOW_TICKS = 1'b1;

    typedef struct packed {
        logic       cmd;
        logic [7:0] dest_address;
        logic [7:0] source_address;
        logic [5:0] dest_port;
        logic [7:0] opcode_byte;
        logic [7:0] channel_byte;
        logic [7:0] value_byte;
    } t_item;

    typedef struct packed {
        logic [7:0] node_address;
        logic [8:0] window_ticks;
    } t_cfg;

    typedef struct packed {
        logic [CHANNELS-1:0] channel_enables;
        logic [7:0]          level_ch0;
        logic [7:0]          level_ch1;
        logic [7:0]          level_ch2;
        logic [7:0]          level_ch3;
        logic                led_toggle;
        logic                pong_valid;
        logic [7:0]          pong_dest;
        logic                reset_request;
    } t_result;

    localparam logic [7:0] GAMMA_ROM [256] = '{
        8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,
        8'd1,8'd2,8'd2,8'd2,8'd2,8'd2,8'd2,8'd2,8'd2,8'd2,8'd2,8'd2,8'd2,8'd2,8'd2,8'd2,
        8'd2,8'd2,8'd2,8'd2,8'd2,8'd2,8'd2,8'd2,8'd3,8'd3,8'd3,8'd3,8'd3,8'd3,8'd3,8'd3,
        8'd3,8'd3,8'd3,8'd3,8'd3,8'd3,8'd3,8'd3,8'd3,8'd3,8'd4,8'd4,8'd4,8'd4,8'd4,8'd4,
        8'd4,8'd4,8'd4,8'd4,8'd4,8'd4,8'd5,8'd5,8'd5,8'd5,8'd5,8'd5,8'd5,8'd5,8'd5,8'd6,
        8'd6,8'd6,8'd6,8'd6,8'd6,8'd6,8'd6,8'd7,8'd7,8'd7,8'd7,8'd7,8'd7,8'd8,8'd8,8'd8,
        8'd8,8'd8,8'd8,8'd9,8'd9,8'd9,8'd9,8'd9,8'd10,8'd10,8'd10,8'd10,8'd10,8'd11,8'd11,
        8'd11,8'd11,8'd12,8'd12,8'd12,8'd12,8'd13,8'd13,8'd13,8'd14,8'd14,8'd14,8'd14,
        8'd15,8'd15,8'd15,8'd16,8'd16,8'd16,8'd17,8'd17,8'd18,8'd18,8'd18,8'd19,8'd19,
        8'd20,8'd20,8'd21,8'd21,8'd21,8'd22,8'd22,8'd23,8'd23,8'd24,8'd24,8'd25,8'd25,
        8'd26,8'd27,8'd27,8'd28,8'd28,8'd29,8'd30,8'd30,8'd31,8'd32,8'd32,8'd33,8'd34,
        8'd35,8'd35,8'd36,8'd37,8'd38,8'd39,8'd39,8'd40,8'd41,8'd42,8'd43,8'd44,8'd45,
        8'd46,8'd47,8'd48,8'd49,8'd50,8'd51,8'd52,8'd53,8'd55,8'd56,8'd57,8'd58,8'd59,
        8'd61,8'd62,8'd63,8'd65,8'd66,8'd68,8'd69,8'd71,8'd72,8'd74,8'd76,8'd77,8'd79,
        8'd81,8'd82,8'd84,8'd86,8'd88,8'd90,8'd92,8'd94,8'd96,8'd98,8'd100,8'd102,8'd105,
        8'd107,8'd109,8'd112,8'd114,8'd117,8'd119,8'd122,8'd124,8'd127,8'd130,8'd133,
        8'd136,8'd139,8'd142,8'd145,8'd148,8'd151,8'd155,8'd158,8'd162,8'd165,8'd169,
        8'd172,8'd176,8'd180,8'd184,8'd188,8'd192,8'd196,8'd201,8'd205,8'd210,8'd214,
        8'd219,8'd224,8'd229,8'd234,8'd239,8'd244,8'd250,8'd255
    };

endpackage

// ===== src/cldc_apb_regs.sv =====
// ----------------------------------------------------------------------------
// Lamp dimmer configuration registers
// APB write and read access to the node address and the window length.
// ----------------------------------------------------------------------------
module cldc_apb_regs
    import cldc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    logic [7:0] r_node_address;
    logic [8:0] r_window_ticks;
    logic       wr_en;
    logic       reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_address <= '0;
            r_window_ticks <= WINDOW_DEFAULT;
        end else if (wr_en) begin
            case (reg_sel)
                REG_NODE_ADDRESS: r_node_address <= pwdata[7:0];
                REG_WINDOW_TICKS: r_window_ticks <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_NODE_ADDRESS: prdata = {24'd0, r_node_address};
            REG_WINDOW_TICKS: prdata = {23'd0, r_window_ticks};
            default:          prdata = '0;
        endcase
    end

    assign o_cfg.node_address = r_node_address;
    assign o_cfg.window_ticks = r_window_ticks;

endmodule

// ===== src/cldc_cmd_core.sv =====
// ----------------------------------------------------------------------------
// Lamp dimmer command core
// Holds the lamp state and works out the next state and the result of one item.
// ----------------------------------------------------------------------------
module cldc_cmd_core
    import cldc_pkg::*;
#(
    parameter logic [5:0] LAMP_PORT  = LAMP_PORT_DEF,
    parameter logic [5:0] MGMT_PORT  = MGMT_PORT_DEF,
    parameter logic [7:0] PING_CODE  = PING_CODE_DEF,
    parameter logic [7:0] RESET_CODE = RESET_CODE_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_advance,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    logic [1:0]          r_scene_step,   n_scene_step;
    logic [7:0]          r_ramp_level,   n_ramp_level;
    logic                r_ramp_up,      n_ramp_up;
    logic [8:0]          r_window_count, n_window_count;
    logic [CHANNELS-1:0] r_enable_bits,  n_enable_bits;
    logic [7:0]          r_levels [CHANNELS];
    logic [7:0]          n_levels [CHANNELS];

    logic                addressed;
    logic                mgmt_hit;
    logic                rst_req;
    logic                pong;
    logic                lamp_hit;
    logic                ch_ok;
    logic [CH_W-1:0]     ch_idx;
    logic [7:0]          ramp_next;
    logic [7:0]          gamma_val;

    assign addressed = (i_item.cmd == CMD_MESSAGE) &&
                       (i_item.dest_address == i_cfg.node_address);
    assign mgmt_hit  = addressed && (i_item.dest_port == MGMT_PORT);
    assign rst_req   = mgmt_hit && (i_item.opcode_byte == RESET_CODE);
    assign pong      = mgmt_hit && !rst_req && (i_item.opcode_byte == PING_CODE);
    assign lamp_hit  = addressed && !rst_req && (i_item.dest_port == LAMP_PORT);
    assign ch_ok     = (i_item.channel_byte[7:CH_W] == '0);
    assign ch_idx    = i_item.channel_byte[CH_W-1:0];
    assign ramp_next = r_ramp_up ? (r_ramp_level + 8'd1) : (r_ramp_level - 8'd1);
    // Channel 3 drives inverted: 255 - gamma[255 - level].
    assign gamma_val = ~GAMMA_ROM[~ramp_next];

    always_comb begin
        n_scene_step   = r_scene_step;
        n_ramp_level   = r_ramp_level;
        n_ramp_up      = r_ramp_up;
        n_window_count = r_window_count;
        n_enable_bits  = r_enable_bits;
        for (int i = 0; i < CHANNELS; i++) begin
            n_levels[i] = r_levels[i];
        end

        if (i_item.cmd == CMD_TICK) begin
            if (r_window_count != '0) begin
                n_window_count = r_window_count - 9'd1;
            end
        end else if (lamp_hit) begin
            case (i_item.opcode_byte)
                OP_SCENE: begin
                    if (r_window_count == '0) begin
                        if (r_scene_step != SCENE_OFF) begin
                            n_enable_bits = MASK_OFF;
                            n_scene_step  = SCENE_OFF;
                        end else begin
                            n_enable_bits = MASK_ALL;
                            n_scene_step  = SCENE_ALL;
                        end
                    end else begin
                        case (r_scene_step)
                            SCENE_OFF: begin
                                n_enable_bits = MASK_MAIN;
                                n_scene_step  = SCENE_MAIN;
                            end
                            SCENE_MAIN: begin
                                n_enable_bits = MASK_ACCENT;
                                n_scene_step  = SCENE_ACCENT;
                            end
                            SCENE_ACCENT: begin
                                n_enable_bits = MASK_ALL;
                                n_scene_step  = SCENE_ALL;
                            end
                            default: begin
                                n_enable_bits = MASK_OFF;
                                n_scene_step  = SCENE_OFF;
                            end
                        endcase
                    end
                    n_window_count = i_cfg.window_ticks;
                end
                OP_SET_LEVEL: begin
                    if (ch_ok) begin
                        if (ch_idx == CH_W'(CHANNELS - 1)) begin
                            n_levels[ch_idx] = ~i_item.value_byte;
                        end else begin
                            n_levels[ch_idx] = i_item.value_byte;
                        end
                    end
                end
                OP_RAMP_STEP: begin
                    // At either end the step only turns the ramp around.
                    if (r_ramp_up && (r_ramp_level == LEVEL_MAX)) begin
                        n_ramp_up = 1'b0;
                    end else if (!r_ramp_up && (r_ramp_level == '0)) begin
                        n_ramp_up = 1'b1;
                    end else begin
                        n_ramp_level = ramp_next;
                        for (int i = 0; i < CHANNELS - 1; i++) begin
                            n_levels[i] = ramp_next;
                        end
                        n_levels[CHANNELS-1] = gamma_val;
                    end
                end
                OP_RAMP_FLIP: begin
                    n_ramp_up = !r_ramp_up;
                end
                OP_ENABLE: begin
                    if (ch_ok) begin
                        n_enable_bits[ch_idx] = (i_item.value_byte != '0);
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scene_step   <= SCENE_OFF;
            r_ramp_level   <= LEVEL_MAX;
            r_ramp_up      <= 1'b0;
            r_window_count <= '0;
            r_enable_bits  <= MASK_OFF;
            for (int i = 0; i < CHANNELS; i++) begin
                r_levels[i] <= '0;
            end
        end else if (i_advance) begin
            r_scene_step   <= n_scene_step;
            r_ramp_level   <= n_ramp_level;
            r_ramp_up      <= n_ramp_up;
            r_window_count <= n_window_count;
            r_enable_bits  <= n_enable_bits;
            for (int i = 0; i < CHANNELS; i++) begin
                r_levels[i] <= n_levels[i];
            end
        end
    end

    always_comb begin
        o_result.channel_enables = n_enable_bits;
        o_result.level_ch0       = n_levels[0];
        o_result.level_ch1       = n_levels[1];
        o_result.level_ch2       = n_levels[2];
        o_result.level_ch3       = n_levels[3];
        o_result.led_toggle      = addressed;
        o_result.pong_valid      = pong;
        o_result.pong_dest       = pong ? i_item.source_address : 8'd0;
        o_result.reset_request   = rst_req;
    end

endmodule

// ===== src/can_lamp_dimmer_command_handler.sv =====
// ----------------------------------------------------------------------------
// Lamp dimmer command handler, top level
// Input register, command core and result register with APB configuration.
// ----------------------------------------------------------------------------
// Path: an item is held in the input register, then its result is loaded into
// the result register, which presents it on the result channel.
// Throughput: one item per cycle, as long as the result side is not
// stalled.
// Reset: synchronous, active low; it empties both pipeline stages and loads
// the lamp state and the configuration registers with their reset values.
module can_lamp_dimmer_command_handler
    import cldc_pkg::*;
#(
    parameter logic [5:0] LAMP_PORT  = LAMP_PORT_DEF,
    parameter logic [5:0] MGMT_PORT  = MGMT_PORT_DEF,
    parameter logic [7:0] PING_CODE  = PING_CODE_DEF,
    parameter logic [7:0] RESET_CODE = RESET_CODE_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,

    // Configuration port.
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,

    // Input channel.
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_cmd,
    input  logic [7:0]          i_dest_address,
    input  logic [7:0]          i_source_address,
    input  logic [5:0]          i_dest_port,
    input  logic [7:0]          i_opcode_byte,
    input  logic [7:0]          i_channel_byte,
    input  logic [7:0]          i_value_byte,

    // Result channel.
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [CHANNELS-1:0] o_channel_enables,
    output logic [7:0]          o_level_ch0,
    output logic [7:0]          o_level_ch1,
    output logic [7:0]          o_level_ch2,
    output logic [7:0]          o_level_ch3,
    output logic                o_led_toggle,
    output logic                o_pong_valid,
    output logic [7:0]          o_pong_dest,
    output logic                o_reset_request
);

    t_cfg    cfg;
    t_item   r_item;
    logic    r_in_valid;
    t_result core_result;
    t_result r_result;
    logic    r_out_valid;
    logic    advance;
    logic    in_take;

    cldc_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // The held item moves on when the result register is empty or its
    // content is being taken in this cycle. The state is committed at the
    // same edge, so the next item sees it at once.
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item.cmd            <= i_cmd;
            r_item.dest_address   <= i_dest_address;
            r_item.source_address <= i_source_address;
            r_item.dest_port      <= i_dest_port;
            r_item.opcode_byte    <= i_opcode_byte;
            r_item.channel_byte   <= i_channel_byte;
            r_item.value_byte     <= i_value_byte;
        end
    end

    cldc_cmd_core #(
        .LAMP_PORT  (LAMP_PORT),
        .MGMT_PORT  (MGMT_PORT),
        .PING_CODE  (PING_CODE),
        .RESET_CODE (RESET_CODE)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (r_item),
        .i_cfg     (cfg),
        .o_result  (core_result)
    );

    // The result register holds a finished transfer while the far side
    // stalls; the input register can still take one more item meanwhile.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= core_result;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_channel_enables = r_result.channel_enables;
    assign o_level_ch0       = r_result.level_ch0;
    assign o_level_ch1       = r_result.level_ch1;
    assign o_level_ch2       = r_result.level_ch2;
    assign o_level_ch3       = r_result.level_ch3;
    assign o_led_toggle      = r_result.led_toggle;
    assign o_pong_valid      = r_result.pong_valid;
    assign o_pong_dest       = r_result.pong_dest;
    assign o_reset_request   = r_result.reset_request;

    // A reset request or a pong only ever comes from an addressed message.
    a_flags_need_address: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_reset_request || o_pong_valid) |-> o_led_toggle)
        else $error("reset or pong without an addressed message");

    // Reset takes precedence over ping, so both never appear together.
    a_reset_over_ping: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_reset_request && o_pong_valid))
        else $error("reset request and pong in one result");

    a_pong_dest_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_pong_valid |-> (o_pong_dest == 8'd0))
        else $error("pong destination set without a pong");

    // An accepted item is held in the input register in the next cycle.
    a_take_fills_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> r_in_valid)
        else $error("accepted item lost from the input register");

    // Each advance leaves a result waiting in the next cycle.
    a_advance_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("result register empty after an advance");

endmodule
